// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands. Both expect signals named clk and rst_n in the
// scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// IMD track index parser package
// Result record type, record kinds, status codes and stream layout constants.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    localparam logic [7:0] COMMENT_END   = 8'h1a;
    localparam logic [7:0] MAX_SIZE_CODE = 8'd6;

    localparam logic KIND_TRACK   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd2;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 72;

    // m_tdata bit positions, lowest field first
    localparam int TD_SIZE_LO   = 51;
    localparam int TD_SIZE_HI   = 53;
    localparam int TD_HCOUNT_LO = 54;
    localparam int TD_HCOUNT_HI = 55;
    localparam int TD_TOP_HI    = 67;
    localparam int TD_TRACK_HI  = 53;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  cylinder;
        logic        head_bit;
        logic        cyl_map_present;
        logic        head_map_present;
        logic [31:0] track_offset;
        logic [7:0]  sectors_in_track;
        logic [2:0]  size_code;
        logic [1:0]  head_count;
        logic [9:0]  track_count;
        logic [1:0]  end_status;
        logic        last_result;
    } itp_result_t;

    // Up to two results produced by one byte, in delivery order
    typedef struct packed {
        logic [1:0]  count;
        itp_result_t first;
        itp_result_t second;
    } itp_push_t;

endpackage

`default_nettype wire

// ===== design/imd_track_index_parser.sv =====
// ----------------------------------------------------------------------------
// IMD track index parser
// Indexes an ImageDisk image streamed one byte per transaction.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has room for two
//   results; a final byte that also ends a header makes two results, and
//   the 4-entry result queue absorbs the extra one.
// The byte path is input register -> parser logic -> result queue.
// Reset (rst_n low, asynchronous) empties both stages and returns the parser
//   to comment skip with all counters cleared.
`default_nettype none

module imd_track_index_parser #(
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Image byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [itp_pkg::S_DATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  wire logic        s_tlast,                   // is_final_byte

    // Record stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] cylinder, [8] head_bit, [9] cyl_map_present, [10] head_map_present,
    // [42:11] track_offset, [50:43] sectors_in_track, [53:51] size_code,
    // [55:54] head_count, [65:56] track_count, [67:66] end_status, [71:68] zero
    output logic [itp_pkg::M_DATA_W-1:0] m_tdata,
    output logic             m_tuser,                   // record_kind
    output logic             m_tlast                    // last_result
);
    import itp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        room;
    logic        fire;
    itp_push_t   push;
    itp_result_t res;

    // Process the held byte only when the queue can take two results.
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: load on each accepted transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    itp_parser #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (in_byte_reg),
        .final_byte (in_last_reg),
        .push       (push)
    );

    itp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // Pack the head-of-queue record onto the master side.
    assign m_tdata = {4'b0, res.end_status, res.track_count, res.head_count,
                      res.size_code, res.sectors_in_track, res.track_offset,
                      res.head_map_present, res.cyl_map_present, res.head_bit,
                      res.cylinder};
    assign m_tuser = res.record_kind;
    assign m_tlast = res.last_result;

endmodule

`default_nettype wire

// ===== design/itp_parser.sv =====
// ----------------------------------------------------------------------------
// IMD track index parser core
// Walks comment, track headers, maps and sector records one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_parser #(
    parameter int OFFSET_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        data_byte,
    input  wire logic              final_byte,
    output itp_pkg::itp_push_t     push
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        PH_COMMENT,
        PH_HEADER,
        PH_MAPS,
        PH_TYPE,
        PH_DATA,
        PH_HALT
    } phase_t;

    phase_t                  phase_reg,  phase_next;
    logic [OFFSET_WIDTH-1:0] pos_reg,    pos_next;
    logic [OFFSET_WIDTH-1:0] start_reg,  start_next;
    logic [13:0]             skip_reg,   skip_next;
    logic [7:0]              cyl_reg,    cyl_next;
    logic [2:0]              hbits_reg,  hbits_next;   // {bit7, bit6, bit0}
    logic [7:0]              cnt_reg,    cnt_next;
    logic [2:0]              size_reg,   size_next;
    logic [2:0]              idx_reg,    idx_next;
    logic [7:0]              left_reg,   left_next;
    logic                    two_reg,    two_next;
    logic [10:0]             tracks_reg, tracks_next;

    logic [1:0]              map_mult;
    logic [9:0]              maps;
    logic [13:0]             skip_dec;
    logic [7:0]              left_dec;
    logic [10:0]             tc_full;
    logic                    rec_valid;
    logic [OFFSET_WIDTH+31:0] start_ext;
    itp_result_t             track_rec;
    itp_result_t             summary_rec;

    assign map_mult  = 2'd1 + {1'b0, hbits_reg[2]} + {1'b0, hbits_reg[1]};
    assign maps      = {2'b00, cnt_reg} * {8'b0, map_mult};
    assign skip_dec  = (skip_reg != 14'd0) ? skip_reg - 14'd1 : 14'd0;
    assign left_dec  = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
    assign start_ext = {32'b0, start_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg + 1'b1;
        start_next  = start_reg;
        skip_next   = skip_reg;
        cyl_next    = cyl_reg;
        hbits_next  = hbits_reg;
        cnt_next    = cnt_reg;
        size_next   = size_reg;
        idx_next    = idx_reg;
        left_next   = left_reg;
        two_next    = two_reg;
        tracks_next = tracks_reg;
        rec_valid   = 1'b0;

        case (phase_reg)
            PH_COMMENT:
            begin
                if (data_byte == COMMENT_END)
                begin
                    phase_next = PH_HEADER;
                    idx_next   = 3'd0;
                end
            end
            PH_HEADER:
            begin
                case (idx_reg)
                    3'd0:    start_next = pos_reg;
                    3'd1:    cyl_next   = data_byte;
                    3'd2:    hbits_next = {data_byte[7], data_byte[6], data_byte[0]};
                    3'd3:    cnt_next   = data_byte;
                    default: ;
                endcase
                if (idx_reg >= 3'd4)
                begin
                    idx_next = 3'd0;
                    if (data_byte > MAX_SIZE_CODE)
                    begin
                        phase_next = PH_HALT;
                    end
                    else
                    begin
                        rec_valid = 1'b1;
                        size_next = data_byte[2:0];
                        if (tracks_reg != 11'h7ff)
                            tracks_next = tracks_reg + 11'd1;
                        if (hbits_reg[0])
                            two_next = 1'b1;
                        left_next = cnt_reg;
                        if (cnt_reg != 8'd0)
                        begin
                            skip_next  = {4'b0, maps};
                            phase_next = PH_MAPS;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_MAPS, PH_DATA:
            begin
                skip_next = skip_dec;
                if (skip_dec == 14'd0)
                    phase_next = (left_reg == 8'd0) ? PH_HEADER : PH_TYPE;
            end
            PH_TYPE:
            begin
                left_next = left_dec;
                if (data_byte == 8'd0)
                begin
                    phase_next = (left_dec == 8'd0) ? PH_HEADER : PH_TYPE;
                end
                else if (data_byte[0] && data_byte[7:3] == 5'd0)
                begin
                    skip_next  = 14'd128 << size_reg;
                    phase_next = PH_DATA;
                end
                else
                begin
                    skip_next  = 14'd1;
                    phase_next = PH_DATA;
                end
            end
            default: ;
        endcase

        // Track record from the completed header
        track_rec                  = '0;
        track_rec.record_kind      = KIND_TRACK;
        track_rec.cylinder         = cyl_reg;
        track_rec.head_bit         = hbits_reg[0];
        track_rec.cyl_map_present  = hbits_reg[2];
        track_rec.head_map_present = hbits_reg[1];
        track_rec.track_offset     = start_ext[31:0];
        track_rec.sectors_in_track = cnt_reg;
        track_rec.size_code        = data_byte[2:0];
        track_rec.last_result      = !final_byte;

        // Summary built from the state this byte leaves behind
        tc_full                 = two_next ? (tracks_next >> 1) : tracks_next;
        summary_rec             = '0;
        summary_rec.record_kind = KIND_SUMMARY;
        summary_rec.head_count  = two_next ? 2'd2 : 2'd1;
        summary_rec.track_count = tc_full[10] ? 10'h3ff : tc_full[9:0];
        if (phase_next == PH_HALT)
            summary_rec.end_status = STATUS_BAD_SIZE;
        else if (phase_next != PH_HEADER || idx_next != 3'd0)
            summary_rec.end_status = STATUS_TRUNCATED;
        else
            summary_rec.end_status = STATUS_OK;
        summary_rec.last_result = 1'b1;

        push.count  = fire ? ({1'b0, rec_valid} + {1'b0, final_byte}) : 2'd0;
        push.first  = rec_valid ? track_rec : summary_rec;
        push.second = summary_rec;

        // Summary closes the image: start over for the next one
        if (final_byte)
        begin
            phase_next  = PH_COMMENT;
            pos_next    = '0;
            start_next  = '0;
            skip_next   = '0;
            cyl_next    = '0;
            hbits_next  = '0;
            cnt_next    = '0;
            size_next   = '0;
            idx_next    = '0;
            left_next   = '0;
            two_next    = 1'b0;
            tracks_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COMMENT;
            pos_reg    <= '0;
            start_reg  <= '0;
            skip_reg   <= '0;
            cyl_reg    <= '0;
            hbits_reg  <= '0;
            cnt_reg    <= '0;
            size_reg   <= '0;
            idx_reg    <= '0;
            left_reg   <= '0;
            two_reg    <= 1'b0;
            tracks_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            skip_reg   <= skip_next;
            cyl_reg    <= cyl_next;
            hbits_reg  <= hbits_next;
            cnt_reg    <= cnt_next;
            size_reg   <= size_next;
            idx_reg    <= idx_next;
            left_reg   <= left_next;
            two_reg    <= two_next;
            tracks_reg <= tracks_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/itp_out_queue.sv =====
// ----------------------------------------------------------------------------
// IMD track index parser result queue
// Small queue that takes up to two results per cycle and delivers one.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_out_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire itp_pkg::itp_push_t push,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_ready,
    output itp_pkg::itp_result_t out_result
);
    import itp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    itp_result_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_second;
    logic             pop;

    assign out_valid  = (cnt_reg != '0);
    assign pop        = out_valid && out_ready;
    assign room       = (cnt_reg <= (PTR_W+1)'(QUEUE_DEPTH - 2));
    assign out_result = mem[rd_reg];
    assign wr_second  = wr_reg + 1'b1;
    assign wr_next    = wr_reg + PTR_W'(push.count);
    assign rd_next    = rd_reg + PTR_W'(pop);
    assign cnt_next   = cnt_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_second] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/itp_checker.sv =====
// ----------------------------------------------------------------------------
// IMD track index parser checker
// Port-level checks on the record stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [itp_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast
);
    import itp_pkg::*;

    `ITP_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "record changed while stalled")

    `ITP_ASSERT_IMP(a_summary_last, m_tvalid && m_tuser == KIND_SUMMARY, m_tlast,
        "summary not marked last")

    `ITP_ASSERT_IMP(a_summary_heads, m_tvalid && m_tuser == KIND_SUMMARY,
        m_tdata[TD_HCOUNT_HI:TD_HCOUNT_LO] == 2'd1 ||
        m_tdata[TD_HCOUNT_HI:TD_HCOUNT_LO] == 2'd2,
        "summary head count out of range")

    `ITP_ASSERT_IMP(a_track_fields, m_tvalid && m_tuser == KIND_TRACK,
        m_tdata[TD_TOP_HI:TD_TRACK_HI+1] == '0 &&
        m_tdata[TD_SIZE_HI:TD_SIZE_LO] <= MAX_SIZE_CODE[2:0],
        "track record carries summary bits or bad size code")

endmodule

bind imd_track_index_parser itp_checker u_itp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// IMD track index parser testbench
// Streams disk images into the parser one byte per transaction and checks
// every track record and end-of-image summary against a cycle-free model of
// the indexer. A short table of hand-built images comes first. Random
// images follow: mostly well-formed, some truncated, some with a bad size
// code, some pure noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import itp_pkg::*;

    localparam int RANDOM_ITEMS   = 1450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    // Sector record type with no body
    localparam logic [7:0] SECTOR_NONE = 8'h00;

    typedef enum logic [2:0] {
        SCAN_COMMENT,
        SCAN_HEADER,
        SCAN_MAPS,
        SCAN_TYPE,
        SCAN_DATA,
        SCAN_HALT
    } scan_t;

    // One row of the directed table. When known is set, the summary fields
    // are typed in; otherwise every result comes from the model below.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       known;
        logic [1:0] heads;
        logic [9:0] tracks;
        logic [1:0] status;
    } stim_row_t;

    localparam stim_row_t DIRECTED [27] = '{
        // empty image: terminator is also the last byte
        '{COMMENT_END, 1'b1, 1'b1, 2'd1, 10'd0, STATUS_OK},
        // comment never terminated
        '{8'h41,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b1, 1'b1, 2'd1, 10'd0, STATUS_TRUNCATED},
        // size code 7 halts the parser; trailing bytes are ignored
        '{COMMENT_END, 1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h07,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'hff,       1'b1, 1'b1, 2'd1, 10'd0, STATUS_BAD_SIZE},
        // header ends on the last byte: track record, then summary
        '{COMMENT_END, 1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h05,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'hff,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'hc1,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h06,       1'b1, 1'b0, 2'd0, 10'd0, STATUS_OK},
        // two sectors: map, one empty record, one fill record
        '{COMMENT_END, 1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h01,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h02,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h00,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h01,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h02,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{SECTOR_NONE, 1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h02,       1'b0, 1'b0, 2'd0, 10'd0, STATUS_OK},
        '{8'h55,       1'b1, 1'b0, 2'd0, 10'd0, STATUS_OK}
    };

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int tx_idle_pct = 22;
    int rx_idle_pct = 55;
    int items_sent  = 0;
    int mismatches  = 0;

    itp_result_t queued_records [$];
    logic [7:0]  image_bytes [$];

    // Indexer model state
    scan_t       scan;
    logic [31:0] stream_pos;
    logic [31:0] trk_start;
    logic [13:0] skip_left;
    logic [7:0]  hdr_cyl;
    logic [7:0]  hdr_head;
    logic [7:0]  hdr_nsec;
    logic [2:0]  hdr_size;
    logic [2:0]  hdr_idx;
    logic [7:0]  sec_left;
    logic        two_heads;
    logic [10:0] trk_seen;
    logic        halted;

    imd_track_index_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Indexer model
    // ------------------------------------------------------------------

    // Return the model to the start of a new image.
    task automatic clear_index();
        scan       = SCAN_COMMENT;
        stream_pos = '0;
        trk_start  = '0;
        skip_left  = '0;
        hdr_cyl    = '0;
        hdr_head   = '0;
        hdr_nsec   = '0;
        hdr_size   = '0;
        hdr_idx    = '0;
        sec_left   = '0;
        two_heads  = 1'b0;
        trk_seen   = '0;
        halted     = 1'b0;
    endtask

    // After a map or a sector body: next sector record, or next track.
    function automatic scan_t after_body(logic [7:0] left);
        return (left == 8'd0) ? SCAN_HEADER : SCAN_TYPE;
    endfunction

    // Advance the model by one image byte; return up to two records.
    task automatic index_byte(input logic [7:0] b, input logic fin, output int n,
                              output itp_result_t r0, output itp_result_t r1);
        itp_result_t sum;
        int          maps;
        logic [10:0] tc;
        n   = 0;
        r0  = '0;
        r1  = '0;
        sum = '0;
        case (scan)
            SCAN_COMMENT:
            begin
                if (b == COMMENT_END)
                begin
                    scan    = SCAN_HEADER;
                    hdr_idx = '0;
                end
            end
            SCAN_HEADER:
            begin
                if (hdr_idx == 3'd0)
                    trk_start = stream_pos;
                case (hdr_idx)
                    3'd1: hdr_cyl  = b;
                    3'd2: hdr_head = b;
                    3'd3: hdr_nsec = b;
                    default: ;
                endcase
                if (hdr_idx >= 3'd4)
                begin
                    hdr_idx = '0;
                    if (b > MAX_SIZE_CODE)
                    begin
                        halted = 1'b1;
                        scan   = SCAN_HALT;
                    end
                    else
                    begin
                        hdr_size            = b[2:0];
                        r0.record_kind      = KIND_TRACK;
                        r0.cylinder         = hdr_cyl;
                        r0.head_bit         = hdr_head[0];
                        r0.cyl_map_present  = hdr_head[7];
                        r0.head_map_present = hdr_head[6];
                        r0.track_offset     = trk_start;
                        r0.sectors_in_track = hdr_nsec;
                        r0.size_code        = hdr_size;
                        n = 1;
                        if (trk_seen < 11'd2047)
                            trk_seen++;
                        if (hdr_head[0])
                            two_heads = 1'b1;
                        sec_left = hdr_nsec;
                        // sector numbering map, then optional cylinder and head maps
                        maps = int'(hdr_nsec) * (1 + int'(hdr_head[7]) + int'(hdr_head[6]));
                        if (maps > 0)
                        begin
                            skip_left = 14'(maps);
                            scan      = SCAN_MAPS;
                        end
                        else
                            scan = after_body(sec_left);
                    end
                end
                else
                    hdr_idx++;
            end
            SCAN_MAPS, SCAN_DATA:
            begin
                if (skip_left > 14'd0)
                    skip_left--;
                if (skip_left == 14'd0)
                    scan = after_body(sec_left);
            end
            SCAN_TYPE:
            begin
                if (sec_left > 8'd0)
                    sec_left--;
                if (b == SECTOR_NONE)
                    scan = after_body(sec_left);
                else
                begin
                    // types 1, 3, 5 and 7 carry a full sector; the rest one fill byte
                    if (b[7:3] == 5'd0 && b[0])
                        skip_left = 14'd128 << hdr_size;
                    else
                        skip_left = 14'd1;
                    scan = SCAN_DATA;
                end
            end
            default: ;
        endcase

        stream_pos++;

        if (fin)
        begin
            tc = two_heads ? (trk_seen >> 1) : trk_seen;
            if (tc > 11'd1023)
                tc = 11'd1023;
            sum.record_kind = KIND_SUMMARY;
            sum.head_count  = two_heads ? 2'd2 : 2'd1;
            sum.track_count = tc[9:0];
            if (halted)
                sum.end_status = STATUS_BAD_SIZE;
            else if (scan != SCAN_HEADER || hdr_idx != 3'd0)
                sum.end_status = STATUS_TRUNCATED;
            else
                sum.end_status = STATUS_OK;
            if (n == 0)
                r0 = sum;
            else
                r1 = sum;
            n++;
            clear_index();
        end

        if (n == 1)
            r0.last_result = 1'b1;
        else if (n == 2)
            r1.last_result = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Byte stream side
    // ------------------------------------------------------------------

    // Present one byte, with random idle cycles in front, and hold it until
    // the transaction completes. Returns in the time step of acceptance.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stream the whole image buffer, last byte marked, predicting as we go.
    task automatic send_image();
        int          n;
        itp_result_t r0;
        itp_result_t r1;
        logic        fin;
        foreach (image_bytes[i])
        begin
            fin = (i == image_bytes.size() - 1);
            send_byte(image_bytes[i], fin);
            index_byte(image_bytes[i], fin, n, r0, r1);
            if (n > 0)
                queued_records.push_back(r0);
            if (n > 1)
                queued_records.push_back(r1);
        end
    endtask

    // Build a random image: short comment, a few tracks with maps and
    // sector records. Some images get a bad size code, some are cut short.
    // With widest set, one track carries a single sector of the largest size.
    task automatic build_image(input bit widest);
        int         ntr;
        int         nsec;
        int         nmaps;
        int         bad_at;
        int         cut;
        int         r;
        logic [7:0] head;
        logic [7:0] size;
        logic [7:0] kind;
        image_bytes.delete();
        repeat ($urandom_range(4))
        begin
            kind = 8'($urandom_range(255));
            if (kind == COMMENT_END)
                kind = 8'h20;
            image_bytes.push_back(kind);
        end
        image_bytes.push_back(COMMENT_END);
        ntr    = widest ? 1 : int'($urandom_range(4));
        bad_at = (ntr > 0 && $urandom_range(99) < 8) ? int'($urandom_range(ntr - 1)) : -1;
        for (int t = 0; t < ntr; t++)
        begin
            head = 8'($urandom_range(255));
            r    = $urandom_range(99);
            if (widest)
                nsec = 1;
            else if (r < 15)
                nsec = 0;
            else if (r < 97)
                nsec = $urandom_range(1, 4);
            else
                nsec = $urandom_range(5, 255);
            image_bytes.push_back(8'($urandom_range(255)));
            image_bytes.push_back(8'($urandom_range(255)));
            image_bytes.push_back(head);
            image_bytes.push_back(8'(nsec));
            if (t == bad_at)
            begin
                // bad size code, then junk that the halted parser ignores
                image_bytes.push_back(8'($urandom_range(7, 255)));
                repeat ($urandom_range(6))
                    image_bytes.push_back(8'($urandom_range(255)));
                break;
            end
            size = widest ? 8'(MAX_SIZE_CODE) : 8'($urandom_range(6));
            image_bytes.push_back(size);
            nmaps = nsec * (1 + int'(head[7]) + int'(head[6]));
            repeat (nmaps)
                image_bytes.push_back(8'($urandom_range(255)));
            repeat (nsec)
            begin
                r = $urandom_range(99);
                // keep full-sector bodies small and few except in the widest image
                if (widest || (size <= 8'd1 && nsec <= 4 && r < 35))
                begin
                    image_bytes.push_back(8'(1 + 2 * $urandom_range(3)));
                    repeat (128 << size)
                        image_bytes.push_back(8'($urandom_range(255)));
                end
                else if (r < 70)
                    image_bytes.push_back(SECTOR_NONE);
                else
                begin
                    kind = 8'($urandom_range(2, 255));
                    if (kind <= 8'd7 && kind[0])
                        kind = kind + 8'd1;
                    image_bytes.push_back(kind);
                    image_bytes.push_back(8'($urandom_range(255)));
                end
            end
        end
        // cut some images short anywhere
        if (bad_at < 0 && image_bytes.size() > 1 && $urandom_range(99) < 15)
        begin
            cut = $urandom_range(image_bytes.size() - 2);
            while (image_bytes.size() > cut + 1)
                void'(image_bytes.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Record side: random backpressure and checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : record_check
        itp_result_t got;
        itp_result_t want;
        string       diff;
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.record_kind      = m_tuser;
            got.cylinder         = m_tdata[7:0];
            got.head_bit         = m_tdata[8];
            got.cyl_map_present  = m_tdata[9];
            got.head_map_present = m_tdata[10];
            got.track_offset     = m_tdata[42:11];
            got.sectors_in_track = m_tdata[50:43];
            got.size_code        = m_tdata[53:51];
            got.head_count       = m_tdata[55:54];
            got.track_count      = m_tdata[65:56];
            got.end_status       = m_tdata[67:66];
            got.last_result      = m_tlast;
            if (queued_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected record: %p", got);
            end
            else
            begin
                want = queued_records.pop_front();
                diff = "";
                if (got.record_kind !== want.record_kind)
                    diff = {diff, " record_kind"};
                if (got.cylinder !== want.cylinder)
                    diff = {diff, " cylinder"};
                if (got.head_bit !== want.head_bit)
                    diff = {diff, " head_bit"};
                if (got.cyl_map_present !== want.cyl_map_present)
                    diff = {diff, " cyl_map_present"};
                if (got.head_map_present !== want.head_map_present)
                    diff = {diff, " head_map_present"};
                if (got.track_offset !== want.track_offset)
                    diff = {diff, " track_offset"};
                if (got.sectors_in_track !== want.sectors_in_track)
                    diff = {diff, " sectors_in_track"};
                if (got.size_code !== want.size_code)
                    diff = {diff, " size_code"};
                if (got.head_count !== want.head_count)
                    diff = {diff, " head_count"};
                if (got.track_count !== want.track_count)
                    diff = {diff, " track_count"};
                if (got.end_status !== want.end_status)
                    diff = {diff, " end_status"};
                if (got.last_result !== want.last_result)
                    diff = {diff, " last_result"};
                if (diff != "")
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("record mismatch in%s: expected %p, got %p", diff, want, got);
                end
            end
        end
    end

    // Abort when no transaction completes on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int          n;
        itp_result_t r0;
        itp_result_t r1;
        itp_result_t fixed_sum;
        clear_index();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed-in summaries replace the model's
        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i].data, DIRECTED[i].fin);
            index_byte(DIRECTED[i].data, DIRECTED[i].fin, n, r0, r1);
            if (DIRECTED[i].known)
            begin
                if (n > 1)
                    queued_records.push_back(r0);
                fixed_sum             = '0;
                fixed_sum.record_kind = KIND_SUMMARY;
                fixed_sum.head_count  = DIRECTED[i].heads;
                fixed_sum.track_count = DIRECTED[i].tracks;
                fixed_sum.end_status  = DIRECTED[i].status;
                fixed_sum.last_result = 1'b1;
                queued_records.push_back(fixed_sum);
            end
            else
            begin
                if (n > 0)
                    queued_records.push_back(r0);
                if (n > 1)
                    queued_records.push_back(r1);
            end
        end

        // Random images; swap the idle pattern, then drop idling altogether
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= 1000)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (items_sent >= 500)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 22;
            end
            if ($urandom_range(99) < 10)
            begin
                // noise: random bytes, the last one marked final
                image_bytes.delete();
                repeat ($urandom_range(1, 16))
                    image_bytes.push_back(8'($urandom_range(255)));
            end
            else
                build_image(1'b0);
            send_image();
        end
        s_tvalid <= 1'b0;

        while (queued_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/itp_pkg.sv
design/itp_parser.sv
design/itp_out_queue.sv
design/imd_track_index_parser.sv
design/itp_checker.sv
bench/tb.sv
